// ===== rtl/lcdt_pkg.sv =====
// Package with shared constants, codes and types for the LCD line and frame timing block.
`timescale 1ns / 1ps
`default_nettype none

package lcdt_pkg;

    localparam int COL_W  = 7;
    localparam int LINE_W = 8;
    localparam int DATA_W = 8;

    localparam logic [COL_W-1:0]  LAST_COLUMN = COL_W'(113);
    localparam logic [LINE_W-1:0] LAST_LINE   = LINE_W'(153);

    // Columns at which the control pin is strobed low.
    localparam logic [COL_W-1:0] STROBE_COL_A = COL_W'(0);
    localparam logic [COL_W-1:0] STROBE_COL_B = COL_W'(7);
    localparam logic [COL_W-1:0] STROBE_COL_C = COL_W'(45);
    localparam logic [COL_W-1:0] STROBE_COL_D = COL_W'(83);

    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_RD_LINE   = 2'd1,
        ACT_RD_CMP    = 2'd2,
        ACT_WR_CMP    = 2'd3
    } t_action;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column_count;
        logic              line_match;
        logic              in_vblank;
        logic              line_end_pulse;
        logic              visible_line_end;
        logic              control_pin;
        logic              latch_pin;
        logic              alternate_pin;
        logic              vsync_pin;
    } t_result;

    // True when both vertical blank bits of a line number are set.
    function automatic logic vblank_bits(input logic [LINE_W-1:0] l);
        return l[7] & l[4];
    endfunction

    function automatic logic is_strobe_column(input logic [COL_W-1:0] c);
        return (c == STROBE_COL_A) || (c == STROBE_COL_B) ||
               (c == STROBE_COL_C) || (c == STROBE_COL_D);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcdt_state.sv =====
// Timing counters, flags and compare register with their next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module lcdt_state
    import lcdt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_action           i_action,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic              i_div_bit6,
    input  wire logic              i_div_bit7,
    input  wire logic              i_lcd_enable,
    output t_result                o_result
);

    logic [COL_W-1:0]  r_column,    n_column;
    logic [LINE_W-1:0] r_line,      n_line;
    logic [DATA_W-1:0] r_cmp,       n_cmp;
    logic r_line_end,  n_line_end;
    logic r_vblank,    n_vblank;
    logic r_line_par,  n_line_par;
    logic r_frame_par, n_frame_par;
    logic r_match,     n_match;
    logic r_strobe,    n_strobe;
    logic r_first,     n_first;
    logic r_vis_end,   n_vis_end;

    logic              wrap;
    logic              last_line;
    logic [LINE_W-1:0] step_line;
    logic              step_vb;
    logic [DATA_W-1:0] rd;

    always_comb begin
        wrap      = (r_column >= LAST_COLUMN);
        last_line = (r_line == LAST_LINE);
        step_line = last_line ? '0 : r_line + LINE_W'(1);
        step_vb   = vblank_bits(step_line);

        n_column    = r_column;
        n_line      = r_line;
        n_cmp       = r_cmp;
        n_line_end  = r_line_end;
        n_vblank    = r_vblank;
        n_line_par  = r_line_par;
        n_frame_par = r_frame_par;
        n_match     = r_match;
        n_strobe    = r_strobe;
        n_first     = r_first;
        n_vis_end   = r_vis_end;
        rd          = '0;

        unique case (i_action)
            ACT_TICK: begin
                n_match = (r_line == r_cmp);
                if (wrap) begin
                    n_column   = '0;
                    n_line     = step_line;
                    n_line_par = ~r_line_par;
                    // The frame parity flips on entry into vertical blank.
                    if (step_vb && !r_vblank) begin
                        n_frame_par = ~r_frame_par;
                    end
                    n_vblank = step_vb;
                    n_first  = (step_line == '0);
                end else begin
                    n_column = r_column + COL_W'(1);
                end
                n_line_end = (n_column == LAST_COLUMN);
                n_vis_end  = n_line_end & ~vblank_bits(n_line);
                n_strobe   = is_strobe_column(n_column);
            end
            ACT_RD_LINE: begin
                rd = r_line;
            end
            ACT_RD_CMP: begin
                rd = r_cmp;
            end
            ACT_WR_CMP: begin
                n_cmp = i_write_data;
            end
            default: begin
                rd = '0;
            end
        endcase

        o_result.read_data        = rd;
        o_result.line_number      = n_line;
        o_result.column_count     = n_column;
        o_result.line_match       = n_match;
        o_result.in_vblank        = n_vblank;
        o_result.line_end_pulse   = n_line_end;
        o_result.visible_line_end = n_vis_end;
        o_result.control_pin      = ~(n_strobe | n_line_end);
        o_result.latch_pin        = i_lcd_enable ? ~n_line_end : ~i_div_bit6;
        o_result.alternate_pin    = i_lcd_enable ? ~(n_line_par ^ n_frame_par) : ~i_div_bit7;
        o_result.vsync_pin        = ~n_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_line      <= '0;
            r_cmp       <= '0;
            r_line_end  <= 1'b0;
            r_vblank    <= 1'b0;
            r_line_par  <= 1'b0;
            r_frame_par <= 1'b0;
            r_match     <= 1'b0;
            r_strobe    <= 1'b0;
            r_first     <= 1'b0;
            r_vis_end   <= 1'b0;
        end else if (i_step) begin
            r_column    <= n_column;
            r_line      <= n_line;
            r_cmp       <= n_cmp;
            r_line_end  <= n_line_end;
            r_vblank    <= n_vblank;
            r_line_par  <= n_line_par;
            r_frame_par <= n_frame_par;
            r_match     <= n_match;
            r_strobe    <= n_strobe;
            r_first     <= n_first;
            r_vis_end   <= n_vis_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcd_line_frame_timing.sv =====
// Top level of the LCD scanline and frame timing generator with line compare.
//
//  channel   direction  handshake                payload
//  -------   ---------  -----------------------  ------------------------------------
//  input     in         i_valid / o_ready        i_action, i_write_data, i_div_bit6/7
//  result    out        o_valid / i_ready        o_read_data ... o_vsync_pin
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_lcd_enable
//
// For every word, the counters and flags are updated at the edge
// that accepts the word, and its result appears in the output register on the
// next cycle. A new word is accepted every cycle while the result register is
// empty or being drained, so stalls on the result side hold the input side only
// as long as that one register stays full. Reset is synchronous and clears all
// counters, flags, the compare value and the display enable. The config port is
// always ready.
`timescale 1ns / 1ps
`default_nettype none

module lcd_line_frame_timing
    import lcdt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_action,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic              i_div_bit6,
    input  wire logic              i_div_bit7,

    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_lcd_enable,

    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_read_data,
    output logic [LINE_W-1:0]      o_line_number,
    output logic [COL_W-1:0]       o_column_count,
    output logic                   o_line_match,
    output logic                   o_in_vblank,
    output logic                   o_line_end_pulse,
    output logic                   o_visible_line_end,
    output logic                   o_control_pin,
    output logic                   o_latch_pin,
    output logic                   o_alternate_pin,
    output logic                   o_vsync_pin
);

    logic    r_lcd_enable;
    logic    r_valid;
    t_result r_res;
    t_result step_res;
    logic    accept;

    // The result register is free when empty or when its word leaves this cycle.
    assign o_ready     = ~r_valid | i_ready;
    assign accept      = i_valid & o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_lcd_enable <= i_cfg_lcd_enable;
        end
    end

    lcdt_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_action     (t_action'(i_action)),
        .i_write_data (i_write_data),
        .i_div_bit6   (i_div_bit6),
        .i_div_bit7   (i_div_bit7),
        .i_lcd_enable (r_lcd_enable),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset; it is only looked at while r_valid is set.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_valid            = r_valid;
    assign o_read_data        = r_res.read_data;
    assign o_line_number      = r_res.line_number;
    assign o_column_count     = r_res.column_count;
    assign o_line_match       = r_res.line_match;
    assign o_in_vblank        = r_res.in_vblank;
    assign o_line_end_pulse   = r_res.line_end_pulse;
    assign o_visible_line_end = r_res.visible_line_end;
    assign o_control_pin      = r_res.control_pin;
    assign o_latch_pin        = r_res.latch_pin;
    assign o_alternate_pin    = r_res.alternate_pin;
    assign o_vsync_pin        = r_res.vsync_pin;

endmodule

`default_nettype wire
